/* design/sorted_key_table_core_macros.svh */
// Assertion helpers used by the checker of the sorted key table.
`ifndef SORTED_KEY_TABLE_CORE_MACROS_SVH
`define SORTED_KEY_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SKT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("skt: check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SKT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("skt: check failed");

`endif

/* design/skt_pkg.sv */
package skt_pkg;

    localparam int unsigned KIND_W = 3;
    localparam int unsigned KEY_W  = 16;
    localparam int unsigned AGE_W  = 8;
    localparam int unsigned QTY_W  = 16;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned POS_W  = 4;
    localparam int unsigned CNT_W  = 5;

    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
        logic [QTY_W-1:0] quantity;
    } t_rec;

    // Operation held steady for the whole walk down the chain.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [AGE_W-1:0]  age;
        logic [QTY_W-1:0]  quantity;
    } t_ctrl;

    // What one cell hands to the next as the token walks.
    typedef struct packed {
        logic             tok;
        logic             hit;
        logic [POS_W-1:0] pos;
        t_rec             carry;
        t_rec             fnd;
    } t_link;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
        logic [KEY_W-1:0]  found_key;
        logic [AGE_W-1:0]  found_age;
        logic [QTY_W-1:0]  found_quantity;
        logic [CNT_W-1:0]  entry_count;
    } t_res;

endpackage

/* design/skt_if.sv */
interface skt_in_if;
    logic                       valid;
    logic                       ready;
    logic [skt_pkg::KIND_W-1:0] kind;
    logic [skt_pkg::KEY_W-1:0]  key;
    logic [skt_pkg::AGE_W-1:0]  age;
    logic [skt_pkg::QTY_W-1:0]  quantity;

    modport source (output valid, kind, key, age, quantity, input ready);
    modport sink   (input valid, kind, key, age, quantity, output ready);
endinterface

interface skt_out_if;
    logic                       valid;
    logic                       ready;
    logic [skt_pkg::STAT_W-1:0] status;
    logic [skt_pkg::POS_W-1:0]  position;
    logic [skt_pkg::KEY_W-1:0]  found_key;
    logic [skt_pkg::AGE_W-1:0]  found_age;
    logic [skt_pkg::QTY_W-1:0]  found_quantity;
    logic [skt_pkg::CNT_W-1:0]  entry_count;

    modport source (output valid, status, position, found_key, found_age, found_quantity,
                    entry_count, input ready);
    modport sink   (input valid, status, position, found_key, found_age, found_quantity,
                    entry_count, output ready);
endinterface

/* design/skt_cell.sv */
module skt_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned CW  = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  skt_pkg::t_ctrl i_ctrl,
    input  logic [CW-1:0]  i_count,
    input  skt_pkg::t_link i_link,
    output skt_pkg::t_link o_link,
    input  skt_pkg::t_rec  i_right_rec,
    output skt_pkg::t_rec  o_rec
);
    import skt_pkg::*;

    localparam int unsigned PosLsb = IDX % 16;
    localparam logic [POS_W-1:0] MyPos = POS_W'(PosLsb);

    t_rec  r_rec, n_rec;
    t_link r_link, n_link;
    t_rec  w_new;
    logic  w_used;
    logic  w_at_end;
    logic  w_match;

    always_comb begin
        w_new    = '{key: i_ctrl.key, age: i_ctrl.age, quantity: i_ctrl.quantity};
        w_used   = CW'(IDX) < i_count;
        w_at_end = CW'(IDX) == i_count;
        w_match  = w_used && (r_rec.key == i_ctrl.key);
        n_rec    = r_rec;
        n_link   = i_link;
        if (i_link.tok) begin
            case (i_ctrl.kind)
                KIND_INSERT: begin
                    if (w_used) begin
                        if (i_link.hit) begin
                            // ripple: take the displaced record, pass ours on
                            n_rec        = i_link.carry;
                            n_link.carry = r_rec;
                        end else if (i_ctrl.key < r_rec.key) begin
                            n_rec        = w_new;
                            n_link.carry = r_rec;
                            n_link.hit   = 1'b1;
                            n_link.pos   = MyPos;
                        end
                    end else if (w_at_end) begin
                        n_rec = i_link.hit ? i_link.carry : w_new;
                        if (!i_link.hit) begin
                            n_link.pos = MyPos;
                        end
                        n_link.hit = 1'b1;
                    end
                end
                KIND_DELETE: begin
                    if (i_link.hit && w_used) begin
                        n_rec = i_right_rec;
                    end else if (!i_link.hit && w_match) begin
                        n_rec      = i_right_rec;
                        n_link.hit = 1'b1;
                        n_link.pos = MyPos;
                    end
                end
                KIND_LOOKUP: begin
                    if (!i_link.hit && w_match) begin
                        n_link.hit = 1'b1;
                        n_link.pos = MyPos;
                        n_link.fnd = r_rec;
                    end
                end
                KIND_UPDATE: begin
                    if (!i_link.hit && w_match) begin
                        n_rec.quantity = i_ctrl.quantity;
                        n_link.hit     = 1'b1;
                        n_link.pos     = MyPos;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.tok <= 1'b0;
        end else begin
            r_link <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_link = r_link;
    assign o_rec  = r_rec;

endmodule

/* design/sorted_key_table_core.sv */
// Insert, delete, lookup and update walk a token down the chain, one table cell per cycle,
// and give their result once it reaches the tail; a full insert, clear and unused kinds skip
// the walk. One item at a time: a new input is taken only in S_IDLE, and a result held in
// S_FIN waits there until the output register is free.
// Reset clears the entry count, the state, the token and the output valid; records at or
// above the count never reach a result.
module sorted_key_table_core #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    skt_in_if.sink           i_in,
    skt_out_if.source        o_out
);
    import skt_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    t_state        r_state;
    t_ctrl         r_ctrl;
    logic [CW-1:0] r_count;
    t_link         r_head;
    t_res          r_res;
    t_res          r_out;
    logic          r_out_valid;

    // Chain wiring: link g feeds cell g, record g+1 is cell g's right neighbor.
    t_link         w_link [CAPACITY+1];
    t_rec          w_rec  [CAPACITY+1];
    t_link         w_tail;
    logic          w_acc;
    logic          w_take;
    logic          w_load;
    logic          w_full_ins;
    logic [31:0]   w_count_ext;
    t_rec          w_new;

    assign w_link[0]        = r_head;
    assign w_rec[CAPACITY]  = '0;
    assign w_tail           = w_link[CAPACITY];
    assign w_acc            = i_in.valid && i_in.ready;
    assign w_take           = r_out_valid && o_out.ready;
    // the finished result moves into the output register once that is free
    assign w_load           = (r_state == S_FIN) && (!r_out_valid || o_out.ready);
    assign w_full_ins       = (i_in.kind == KIND_INSERT) && (r_count == CapCount);
    assign w_count_ext      = 32'(r_count);
    assign w_new            = '{key: i_in.key, age: i_in.age, quantity: i_in.quantity};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        skt_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (r_ctrl),
            .i_count     (r_count),
            .i_link      (w_link[g]),
            .o_link      (w_link[g+1]),
            .i_right_rec (w_rec[g+1]),
            .o_rec       (w_rec[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head.tok  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // raise valid as a result loads, drop it once the sink takes it
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_ctrl <= '{kind: i_in.kind, key: i_in.key, age: i_in.age,
                                    quantity: i_in.quantity};
                        // a full table turns the insert away without a walk
                        r_res  <= '{status: (w_full_ins ? ST_FULL : ST_OK), default: '0};
                        case (i_in.kind)
                            KIND_INSERT, KIND_DELETE, KIND_LOOKUP, KIND_UPDATE: begin
                                if (w_full_ins) begin
                                    r_state <= S_FIN;
                                end else begin
                                    // launch the token into the first cell
                                    r_head  <= '{tok: 1'b1, hit: 1'b0, pos: '0,
                                                 carry: w_new, fnd: '0};
                                    r_state <= S_RUN;
                                end
                            end
                            KIND_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_FIN;
                            end
                            default: begin
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    r_head.tok <= 1'b0;
                    if (w_tail.tok) begin
                        r_state <= S_FIN;
                        if (r_ctrl.kind == KIND_INSERT) begin
                            r_res.position <= w_tail.pos;
                            r_count        <= r_count + CW'(1);
                        end else if (!w_tail.hit) begin
                            r_res.status <= ST_MISS;
                        end else begin
                            r_res.position <= w_tail.pos;
                            if (r_ctrl.kind == KIND_DELETE) begin
                                r_count <= r_count - CW'(1);
                            end
                            if (r_ctrl.kind == KIND_LOOKUP) begin
                                r_res.found_key      <= w_tail.fnd.key;
                                r_res.found_age      <= w_tail.fnd.age;
                                r_res.found_quantity <= w_tail.fnd.quantity;
                            end
                        end
                    end
                end
                S_FIN: begin
                    // hold the result until the output register is free
                    if (w_load) begin
                        r_out   <= '{status: r_res.status, position: r_res.position,
                                     found_key: r_res.found_key, found_age: r_res.found_age,
                                     found_quantity: r_res.found_quantity,
                                     entry_count: w_count_ext[CNT_W-1:0]};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.position       = r_out.position;
    assign o_out.found_key      = r_out.found_key;
    assign o_out.found_age      = r_out.found_age;
    assign o_out.found_quantity = r_out.found_quantity;
    assign o_out.entry_count    = r_out.entry_count;

endmodule

/* design/skt_checker.sv */
`include "sorted_key_table_core_macros.svh"

module skt_checker #(
    parameter int unsigned CAPACITY = 16
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [skt_pkg::STAT_W-1:0] i_out_status,
    input logic [skt_pkg::POS_W-1:0]  i_out_position,
    input logic [skt_pkg::CNT_W-1:0]  i_out_entry_count
);
    import skt_pkg::*;

    localparam int unsigned CapMod = CAPACITY % 32;
    localparam logic [CNT_W-1:0] CapLsb = CNT_W'(CapMod);

    `SKT_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `SKT_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_status) && $stable(i_out_position) && $stable(i_out_entry_count))
    `SKT_ASSERT_NEXT(a_busy_after_transfer, i_in_valid && i_in_ready, !i_in_ready)
    `SKT_ASSERT_IMPL(a_full_count, i_out_valid && (i_out_status == ST_FULL), i_out_entry_count == CapLsb)

endmodule

bind sorted_key_table_core skt_checker #(
    .CAPACITY (CAPACITY)
) u_skt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_status      (o_out.status),
    .i_out_position    (o_out.position),
    .i_out_entry_count (o_out.entry_count)
);

/* tb/sorted_key_table_core_tb.sv */
`default_nettype none

module sorted_key_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skt_pkg::*;

    localparam int unsigned CAPACITY    = 16;
    localparam int unsigned ORDER_COUNT = 1600;
    // No idling on either side once the run gets this close to its end.
    localparam int unsigned TAIL_ITEMS  = 120;
    // The receiver holds off this long once, after this many results.
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned HOLD_AFTER  = 200;
    // Cycles with no transfer on either side before the run is called hung.
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned DRAIN_WAIT  = CAPACITY + 8;

    localparam int unsigned MODE_FILL  = 0;
    localparam int unsigned MODE_DRAIN = 1;
    localparam int unsigned MODE_MIX   = 2;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Driven values, kept in plain variables so they are known from time zero.
    logic              send_valid    = 1'b0;
    logic [KIND_W-1:0] send_kind     = '0;
    logic [KEY_W-1:0]  send_key      = '0;
    logic [AGE_W-1:0]  send_age      = '0;
    logic [QTY_W-1:0]  send_quantity = '0;
    logic              take_ready    = 1'b0;

    skt_in_if  in_if ();
    skt_out_if out_if ();

    assign in_if.valid    = send_valid;
    assign in_if.kind     = send_kind;
    assign in_if.key      = send_key;
    assign in_if.age      = send_age;
    assign in_if.quantity = send_quantity;
    assign out_if.ready   = take_ready;

    sorted_key_table_core #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Orders waiting to be offered, and the answers the table owes us.
    t_ctrl order_q [$];
    t_res  answer_q [$];

    // Our own copy of the table, updated at each input transfer.
    t_rec  shelf [CAPACITY];
    int    shelf_count = 0;

    int    fail_count   = 0;
    int    quiet_cycles = 0;
    int    order_total  = 0;

    // Sender-side idling state.
    int    send_gap = 0;

    // Receiver-side stall state; the long hold is counted here alone.
    int    stall_left = 0;
    int    hold_left  = 0;
    bit    held_once  = 1'b0;
    int    taken      = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Apply one order to the local table and return the answer it must give.
    function automatic t_res apply_order(input t_ctrl ord);
        t_res res;
        int   idx;
        bit   hit;
        res = '0;
        res.status = ST_OK;
        if (ord.kind == KIND_INSERT) begin
            if (shelf_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                // Walk down from the top, moving larger keys up one slot.
                idx = shelf_count;
                while (idx > 0 && ord.key < shelf[idx-1].key) begin
                    shelf[idx] = shelf[idx-1];
                    idx--;
                end
                shelf[idx].key      = ord.key;
                shelf[idx].age      = ord.age;
                shelf[idx].quantity = ord.quantity;
                shelf_count++;
                res.position = idx[POS_W-1:0];
            end
        end else if (ord.kind == KIND_DELETE || ord.kind == KIND_LOOKUP ||
                     ord.kind == KIND_UPDATE) begin
            // First entry with the key: stop at the first key not below it.
            idx = 0;
            while (idx < shelf_count && shelf[idx].key < ord.key) idx++;
            hit = (idx < shelf_count) && (shelf[idx].key == ord.key);
            if (!hit) begin
                res.status = ST_MISS;
            end else begin
                res.position = idx[POS_W-1:0];
                if (ord.kind == KIND_DELETE) begin
                    for (int j = idx; j + 1 < shelf_count; j++) shelf[j] = shelf[j+1];
                    shelf_count--;
                end else if (ord.kind == KIND_LOOKUP) begin
                    res.found_key      = shelf[idx].key;
                    res.found_age      = shelf[idx].age;
                    res.found_quantity = shelf[idx].quantity;
                end else begin
                    shelf[idx].quantity = ord.quantity;
                end
            end
        end else if (ord.kind == KIND_CLEAR) begin
            shelf_count = 0;
        end
        // Unused kinds fall through: status ok, table untouched.
        res.entry_count = shelf_count[CNT_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
        end
    endtask

    task automatic add_order(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                             input logic [AGE_W-1:0] age, input logic [QTY_W-1:0] quantity);
        t_ctrl ord;
        ord.kind     = kind;
        ord.key      = key;
        ord.age      = age;
        ord.quantity = quantity;
        order_q.push_back(ord);
    endtask

    // Driver: offer the head of the order queue, hold it until the transfer,
    // and drop in idle bursts between orders except near the end.
    always @(posedge i_clk) begin : drive_proc
        logic offer;
        if (!i_rst_n) begin
            send_valid <= 1'b0;
        end else begin
            offer = send_valid;
            if (send_valid && in_if.ready) begin
                void'(order_q.pop_front());
                offer = 1'b0;
                if (order_q.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 17);
            end
            if (!offer) begin
                if (send_gap > 0)
                    send_gap--;
                else if (order_q.size() > 0)
                    offer = 1'b1;
            end
            send_valid <= offer;
            if (offer) begin
                send_kind     <= order_q[0].kind;
                send_key      <= order_q[0].key;
                send_age      <= order_q[0].age;
                send_quantity <= order_q[0].quantity;
            end
        end
    end

    // Receiver: stall in random bursts, and once hold off long enough that the
    // table backs up and stops taking orders.
    always @(posedge i_clk) begin : take_proc
        logic take;
        if (!i_rst_n) begin
            take_ready <= 1'b0;
        end else begin
            if (out_if.valid && take_ready) taken++;
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end else if (!held_once && taken >= HOLD_AFTER) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                take      = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                take = 1'b0;
            end else begin
                take = 1'b1;
                if (taken + TAIL_ITEMS < order_total && $urandom_range(0, 6) == 0)
                    stall_left = $urandom_range(1, 17);
            end
            take_ready <= take;
        end
    end

    // Checker: compare each result transfer with the oldest answer owed, then
    // predict the answer for any order transferred at the same edge.
    always @(posedge i_clk) begin : check_proc
        t_res want;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (answer_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual status %0h position %0h count %0h",
                             $realtime, out_if.status, out_if.position, out_if.entry_count);
                end else begin
                    want = answer_q.pop_front();
                    check_field("status", 32'(want.status), 32'(out_if.status));
                    check_field("position", 32'(want.position), 32'(out_if.position));
                    check_field("found_key", 32'(want.found_key), 32'(out_if.found_key));
                    check_field("found_age", 32'(want.found_age), 32'(out_if.found_age));
                    check_field("found_quantity", 32'(want.found_quantity),
                                32'(out_if.found_quantity));
                    check_field("entry_count", 32'(want.entry_count),
                                32'(out_if.entry_count));
                end
            end
            if (in_if.valid && in_if.ready) begin
                answer_q.push_back(apply_order('{kind: in_if.kind, key: in_if.key,
                                                 age: in_if.age, quantity: in_if.quantity}));
            end
        end
    end

    // Watchdog: count cycles in which nothing moves on either side.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : stimulus
        logic [KEY_W-1:0]  key_base;
        logic [KEY_W-1:0]  k;
        logic [KIND_W-1:0] kind;
        logic [31:0]       draw;
        logic [31:0]       roll;
        int unsigned       spread;
        int unsigned       mode;
        int unsigned       ins_pct;
        int unsigned       del_pct;
        int unsigned       look_pct;
        int unsigned       upd_pct;

        // Directed: empty-table misses, extreme keys and fields, duplicates,
        // each operation, the unused kinds and a clear.
        add_order(KIND_LOOKUP, 16'h0000, 8'h00, 16'h0000);
        add_order(KIND_DELETE, 16'hFFFF, 8'hFF, 16'hFFFF);
        add_order(KIND_UPDATE, 16'h1234, 8'h00, 16'hFFFF);
        add_order(KIND_INSERT, 16'hFFFF, 8'hFF, 16'hFFFF);
        add_order(KIND_INSERT, 16'h0000, 8'h00, 16'h0000);
        add_order(KIND_INSERT, 16'h8000, 8'h5A, 16'hA5A5);
        add_order(KIND_INSERT, 16'h8000, 8'hA5, 16'h5A5A);
        add_order(KIND_INSERT, 16'h7FFF, 8'h01, 16'h0001);
        add_order(KIND_LOOKUP, 16'h8000, 8'h00, 16'h0000);
        add_order(KIND_UPDATE, 16'h8000, 8'h00, 16'h0000);
        add_order(KIND_LOOKUP, 16'h8000, 8'hFF, 16'hFFFF);
        add_order(KIND_DELETE, 16'h8000, 8'h00, 16'h0000);
        add_order(KIND_LOOKUP, 16'h8000, 8'h00, 16'h0000);
        add_order(KIND_LOOKUP, 16'h8001, 8'h00, 16'h0000);
        add_order(KIND_DELETE, 16'hFFFF, 8'h00, 16'h0000);
        add_order(KIND_DELETE, 16'h0000, 8'h00, 16'h0000);
        add_order(3'd5, 16'hFFFF, 8'hFF, 16'hFFFF);
        add_order(3'd6, 16'h5555, 8'hAA, 16'h5555);
        add_order(3'd7, 16'hAAAA, 8'h55, 16'hAAAA);
        add_order(KIND_LOOKUP, 16'h7FFF, 8'h00, 16'h0000);
        add_order(KIND_CLEAR, 16'h7FFF, 8'hFF, 16'hFFFF);
        add_order(KIND_LOOKUP, 16'h7FFF, 8'h00, 16'h0000);
        add_order(KIND_INSERT, 16'h0001, 8'h80, 16'h8000);

        // Random rounds: keys drawn near a base so that hits and duplicates
        // are common, each round biased toward filling, draining or a mix.
        key_base = 16'($urandom);
        spread   = 16;
        while (order_q.size() < ORDER_COUNT) begin
            mode = $urandom_range(0, 2);
            case (mode)
                MODE_FILL: begin
                    ins_pct = 75; del_pct = 8;  look_pct = 8;  upd_pct = 7;
                end
                MODE_DRAIN: begin
                    ins_pct = 20; del_pct = 50; look_pct = 15; upd_pct = 13;
                end
                default: begin
                    ins_pct = 40; del_pct = 25; look_pct = 20; upd_pct = 13;
                end
            endcase
            repeat ($urandom_range(20, 60)) begin
                draw = $urandom;
                k    = key_base + 16'($urandom_range(0, spread - 1));
                if (draw[7:0] < 10)
                    k = draw[31:16];
                else if (draw[7:0] < 14)
                    k = draw[8] ? 16'hFFFF : 16'h0000;
                roll = $urandom_range(0, 99);
                if (roll < ins_pct)
                    kind = KIND_INSERT;
                else if (roll < ins_pct + del_pct)
                    kind = KIND_DELETE;
                else if (roll < ins_pct + del_pct + look_pct)
                    kind = KIND_LOOKUP;
                else if (roll < ins_pct + del_pct + look_pct + upd_pct)
                    kind = KIND_UPDATE;
                else
                    kind = 3'($urandom_range(5, 7));
                add_order(kind, k, 8'($urandom), 16'($urandom));
            end
            // Now and then wipe the table and move to a new key neighborhood.
            if ($urandom_range(0, 3) == 0) begin
                add_order(KIND_CLEAR, 16'($urandom), 8'($urandom), 16'($urandom));
                key_base = 16'($urandom);
                case ($urandom_range(0, 2))
                    0:       spread = 4;
                    1:       spread = 16;
                    default: spread = 64;
                endcase
            end
        end
        order_total = order_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every order to go in and every answer to come back.
        while ((order_q.size() != 0 || answer_q.size() != 0) && quiet_cycles < STALL_LIMIT)
            @(negedge i_clk);
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d orders and %0d answers outstanding",
                     $realtime, quiet_cycles, order_q.size(), answer_q.size());
            $display("*** FAILED ***");
        end else begin
            // Give stray results a chance to show up before the verdict.
            repeat (DRAIN_WAIT) @(negedge i_clk);
            if (fail_count == 0)
                $display("*** PASSED ***");
            else
                $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sorted_key_table_core.f */
+incdir+design
design/skt_pkg.sv
design/skt_if.sv
design/skt_cell.sv
design/sorted_key_table_core.sv
design/skt_checker.sv
tb/sorted_key_table_core_tb.sv
